// ===== hdl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter: item structs, sequencer
// states, lane control group and the reciprocal table for the mean divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bf3_pkg;

    // fixed field widths
    localparam int PIX_W       = 8;
    localparam int CFG_W_BITS  = 11;
    localparam int CFG_H_BITS  = 13;
    localparam int CFG_DATA_W  = 13;
    // row position runs to frame_height+1 during the flush
    localparam int ROW_W       = 14;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;

    localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd1024;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_end;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_MUL,
        S_OUT
    } t_state;

    // control group from the sequencer to every lane
    typedef struct packed {
        logic               load;
        logic               sum_en;
        logic               mul_en;
        logic [2:0]         col_mask;
        logic [2:0]         row_mask;
        logic [RECIP_W-1:0] recip;
    } t_lane_ctl;

    // ceil(2^20 / d): exact floor quotient for sums below 4096
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        r = '0;
        unique case (cnt)
            4'd1:    r = 21'd1048576;
            4'd2:    r = 21'd524288;
            4'd3:    r = 21'd349526;
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209716;
            4'd6:    r = 21'd174763;
            4'd7:    r = 21'd149797;
            4'd8:    r = 21'd131072;
            4'd9:    r = 21'd116509;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/bf3_line_buf.sv =====
// ----------------------------------------------------------------------------
// bf3_line_buf
// Two-row line store in one memory: each word holds the pixel two rows up
// and the pixel one row up for a column. Registered read, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bf3_line_buf #(
    parameter int DEPTH = 1024,
    parameter int DW    = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bf3_lane.sv =====
// ----------------------------------------------------------------------------
// bf3_lane
// One color channel: 3x3 window, masked neighborhood sum, and the mean by
// reciprocal multiply. All lanes run in lockstep under one control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bf3_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bf3_pkg::t_lane_ctl          i_ctl,
    input  logic [bf3_pkg::PIX_W-1:0]   i_top,
    input  logic [bf3_pkg::PIX_W-1:0]   i_mid,
    input  logic [bf3_pkg::PIX_W-1:0]   i_bot,
    output logic [bf3_pkg::PIX_W-1:0]   o_mean
);

    import bf3_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    // r_win[col][row]: col 0 oldest, row 0 top
    logic [PIX_W-1:0]  r_win [3][3];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [PIX_W-1:0]  r_mean;
    logic [PROD_W-1:0] n_prod;

    // window shift and new column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (i_ctl.load) begin
            for (int r = 0; r < 3; r++) begin
                r_win[0][r] <= r_win[1][r];
                r_win[1][r] <= r_win[2][r];
            end
            r_win[2][0] <= i_top;
            r_win[2][1] <= i_mid;
            r_win[2][2] <= i_bot;
        end
    end

    // in-frame neighborhood sum
    always_comb begin
        n_sum = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (i_ctl.col_mask[c] && i_ctl.row_mask[r]) begin
                    n_sum = n_sum + SUM_W'(r_win[c][r]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    // divide by count through the reciprocal
    assign n_prod = PROD_W'(r_sum) * PROD_W'(i_ctl.recip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_mean <= n_prod[RECIP_SHIFT +: PIX_W];
        end
    end

    assign o_mean = r_mean;

endmodule

// ===== hdl/box_filter_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware
// 3x3 mean filter over a raster-order RGB stream of configurable frame size.
// Each result is the per-channel truncated mean of the in-frame pixels around
// a pixel; the result for a pixel leaves once its lower-right neighbor is in,
// and after the frame frame_width+1 drain items flush the rest, the last
// result carrying frame_end. An item that yields no result goes through a
// line-store read, then window load and store write-back; one that yields a
// result goes through read, load, masked sum, reciprocal multiply and output
// register, one item at a time through the sequencer. The next item is taken
// while a result still waits in the output register. Writing frame_width or
// frame_height restarts the frame and drops results still owed. Items that do
// not fit the frame phase (drain during the frame, pixel during the flush)
// are taken and dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  bf3_pkg::t_in_item              i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output bf3_pkg::t_out_item             o_item
);

    import bf3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int PW    = $clog2(MAX_WIDTH + 2);
    localparam int WCMP  = (PW > CFG_W_BITS) ? PW : CFG_W_BITS;
    localparam int LANEW = CHANNELS * PIX_W;
    localparam int MEMW  = 2 * LANEW;

    // configuration
    logic [CFG_W_BITS-1:0] r_fw;
    logic [CFG_H_BITS-1:0] r_fh;

    // frame position
    logic [WCMP-1:0]  r_col;
    logic [ROW_W-1:0] r_row;
    logic [WCMP-1:0]  r_pend;
    logic [WCMP-1:0]  n_col;
    logic [ROW_W-1:0] n_row;
    logic [WCMP-1:0]  n_pend;

    // sequencer
    t_state r_state;
    t_state n_state;

    // per-item context captured at accept
    logic [CW-1:0]    r_addr;
    logic [LANEW-1:0] r_px;
    logic             r_emit;
    logic             r_last;
    logic [2:0]       r_col_mask;
    logic [2:0]       r_row_mask;
    logic [RECIP_W-1:0] r_recip;

    // output register
    logic      r_oval;
    t_out_item r_out;

    logic [WCMP-1:0]  eff_w;
    logic [WCMP-1:0]  fw_ext;
    logic [ROW_W-1:0] eff_h;
    logic             in_acc;
    logic             take;
    logic             emit;
    logic [ROW_W-1:0] cr;
    logic [WCMP-1:0]  cc;
    logic             last;
    logic [2:0]       cmask;
    logic [2:0]       rmask;
    logic [1:0]       ncols;
    logic [1:0]       nrows;
    logic [CNT_W-1:0] cnt;
    logic [LANEW-1:0] px_vec;
    logic [MEMW-1:0]  rd_data;
    logic             ld_out;
    t_lane_ctl        lane_ctl;
    logic [PIX_W-1:0] mean [CHANNELS];
    t_out_item        n_out;

    // effective frame size
    assign fw_ext = WCMP'(r_fw);
    assign eff_w  = (r_fw == '0) ? WCMP'(1)
                  : (fw_ext > WCMP'(MAX_WIDTH)) ? WCMP'(MAX_WIDTH) : fw_ext;
    assign eff_h  = (r_fh == '0) ? ROW_W'(1) : ROW_W'(r_fh);

    // an item enters only while the sequencer is idle
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign take    = in_acc && ((r_row < eff_h) != (i_item.kind == KIND_DRAIN));

    // position of the centered pixel and its in-frame neighbors
    always_comb begin
        emit = (r_pend >= eff_w + WCMP'(1));
        if (r_col != '0) begin
            cr = r_row - ROW_W'(1);
            cc = r_col - WCMP'(1);
        end else begin
            cr = r_row - ROW_W'(2);
            cc = eff_w - WCMP'(1);
        end
        cmask = {(cc + WCMP'(1) < eff_w), 1'b1, (cc != '0)};
        rmask = {(cr + ROW_W'(1) < eff_h), 1'b1, (cr != '0)};
        ncols = 2'd1 + 2'(cmask[0]) + 2'(cmask[2]);
        nrows = 2'd1 + 2'(rmask[0]) + 2'(rmask[2]);
        cnt   = CNT_W'(ncols) * CNT_W'(nrows);
        last  = emit && (cr == eff_h - ROW_W'(1)) && (cc == eff_w - WCMP'(1));
    end

    // frame position advance
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (take) begin
            if (last) begin
                n_col  = '0;
                n_row  = '0;
                n_pend = '0;
            end else begin
                if (!emit) begin
                    n_pend = r_pend + WCMP'(1);
                end
                if (r_col + WCMP'(1) >= eff_w) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + WCMP'(1);
                end
            end
        end
    end

    // configuration and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= RESET_WIDTH;
            r_fh   <= RESET_HEIGHT;
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_fw <= i_cfg_data[CFG_W_BITS-1:0];
                REG_FRAME_HEIGHT: r_fh <= i_cfg_data[CFG_H_BITS-1:0];
                default:          r_fh <= r_fh;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

    // incoming pixel as a lane vector, missing channels zero
    always_comb begin
        px_vec = '0;
        if (i_item.kind == KIND_PIXEL) begin
            for (int k = 0; k < CHANNELS; k++) begin
                case (k)
                    0:       px_vec[k*PIX_W +: PIX_W] = i_item.red_in;
                    1:       px_vec[k*PIX_W +: PIX_W] = i_item.green_in;
                    2:       px_vec[k*PIX_W +: PIX_W] = i_item.blue_in;
                    default: px_vec[k*PIX_W +: PIX_W] = '0;
                endcase
            end
        end
    end

    // item context
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_addr     <= r_col[CW-1:0];
            r_px       <= px_vec;
            r_emit     <= emit;
            r_last     <= last;
            r_col_mask <= cmask;
            r_row_mask <= rmask;
            r_recip    <= recip_of(cnt);
        end
    end

    // line store: upper half two rows up, lower half one row up
    bf3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (MEMW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (r_col[CW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_LOAD),
        .i_wr_addr (r_addr),
        .i_wr_data ({rd_data[LANEW-1:0], r_px})
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        ld_out            = 1'b0;
        lane_ctl.load     = 1'b0;
        lane_ctl.sum_en   = 1'b0;
        lane_ctl.mul_en   = 1'b0;
        lane_ctl.col_mask = r_col_mask;
        lane_ctl.row_mask = r_row_mask;
        lane_ctl.recip    = r_recip;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                lane_ctl.load = 1'b1;
                n_state = r_emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                lane_ctl.sum_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                lane_ctl.mul_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_oval || !i_stall) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // channel lanes
    for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
        bf3_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (lane_ctl),
            .i_top  (rd_data[LANEW + k*PIX_W +: PIX_W]),
            .i_mid  (rd_data[k*PIX_W +: PIX_W]),
            .i_bot  (r_px[k*PIX_W +: PIX_W]),
            .o_mean (mean[k])
        );
    end

    // merge lane results into one item
    always_comb begin
        n_out           = '0;
        n_out.red_out   = mean[0];
        n_out.frame_end = r_last;
        if (CHANNELS > 1) begin
            n_out.green_out = mean[(CHANNELS > 1) ? 1 : 0];
        end
        if (CHANNELS > 2) begin
            n_out.blue_out = mean[(CHANNELS > 2) ? 2 : 0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (ld_out) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_oval;
    assign o_item  = r_out;

    // pending count never passes the emit threshold
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= eff_w + WCMP'(1))
        else $error("pending count above width plus one");

    // column position stays inside the row
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < eff_w)
        else $error("column position outside the frame");

    // row position never goes past the flush rows
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= eff_h + ROW_W'(1))
        else $error("row position past the flush");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_oval && i_stall) |=> (r_state == S_OUT && r_oval))
        else $error("result register overwritten while stalled");

    // a result only follows an item that reached the emit point
    a_emit_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> ($past(r_state) == S_LOAD && r_emit))
        else $error("sum step without an emitting item");

endmodule

// ===== verif/tb_box_filter_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_edge_aware
// Self-checking bench for the edge-aware 3x3 box filter. A scoreboard class
// keeps its own line stores, window and frame position. It predicts each
// neighborhood mean when an item is accepted and checks the results in
// order. Frames of random size and content run under random valid gaps and
// output stalls. Dropped items, aborted frames and the register extremes are
// mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class mean_scoreboard;
    localparam int MAX_COLS = 1024;

    bit [10:0]   width_reg  = 11'd1024;
    bit [12:0]   height_reg = 13'd1024;
    // two rows above the arrival point, per column and channel
    bit [7:0]    row_above2 [MAX_COLS][3];
    bit [7:0]    row_above1 [MAX_COLS][3];
    // win[col][row][ch]: col 0 oldest, row 0 topmost
    bit [7:0]    win [3][3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned steps_taken;
    int unsigned items_used;
    int unsigned errors;
    bf3_pkg::t_out_item means_owed [$];

    function int unsigned cols();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_COLS) return MAX_COLS;
        return width_reg;
    endfunction

    function int unsigned rows();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int owed();
        return means_owed.size();
    endfunction

    function void restart();
        col_pos     = 0;
        row_pos     = 0;
        steps_taken = 0;
    endfunction

    // a register write also restarts the frame
    function void write_reg(logic idx, logic [bf3_pkg::CFG_DATA_W-1:0] data);
        if (idx == bf3_pkg::REG_FRAME_WIDTH) begin
            width_reg = data[10:0];
        end else begin
            height_reg = data;
        end
        restart();
    endfunction

    // advance the filter by one accepted item and queue any mean it yields
    function void note_item(bf3_pkg::t_in_item it);
        int unsigned w, h, col, cr, cc, cnt, sum;
        int i, j, k;
        bit drain, is_last;
        bit [7:0] px [3];
        bit [7:0] mean [3];
        bit cv [3];
        bit rv [3];
        bf3_pkg::t_out_item res;

        w = cols();
        h = rows();
        drain = (it.kind == bf3_pkg::KIND_DRAIN);
        // drain inside the frame or pixel during the flush: dropped
        if ((row_pos < h) == drain) return;
        items_used++;

        px[0] = drain ? 8'd0 : it.red_in;
        px[1] = drain ? 8'd0 : it.green_in;
        px[2] = drain ? 8'd0 : it.blue_in;
        col = col_pos;

        // shift window left, load new column, roll the line stores
        for (k = 0; k < 3; k++) begin
            for (j = 0; j < 3; j++) begin
                win[0][j][k] = win[1][j][k];
                win[1][j][k] = win[2][j][k];
            end
            win[2][0][k] = row_above2[col][k];
            win[2][1][k] = row_above1[col][k];
            win[2][2][k] = px[k];
            row_above2[col][k] = row_above1[col][k];
            row_above1[col][k] = px[k];
        end

        if (steps_taken >= w + 1) begin
            // centre pixel lags one row and one column behind the arrival
            if (col >= 1) begin
                cr = row_pos - 1;
                cc = col - 1;
            end else begin
                cr = row_pos - 2;
                cc = w - 1;
            end
            cv[0] = (cc >= 1);
            cv[1] = 1'b1;
            cv[2] = (cc + 1 < w);
            rv[0] = (cr >= 1);
            rv[1] = 1'b1;
            rv[2] = (cr + 1 < h);
            cnt = 0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    if (cv[i] && rv[j]) cnt++;
            for (k = 0; k < 3; k++) begin
                sum = 0;
                for (i = 0; i < 3; i++)
                    for (j = 0; j < 3; j++)
                        if (cv[i] && rv[j]) sum += win[i][j][k];
                mean[k] = 8'(sum / cnt);
            end
            is_last = (cr == h - 1) && (cc == w - 1);
            res.red_out   = mean[0];
            res.green_out = mean[1];
            res.blue_out  = mean[2];
            res.frame_end = is_last;
            means_owed.push_back(res);
            // next frame starts right after the flagged result
            if (is_last) begin
                restart();
                return;
            end
        end else begin
            steps_taken++;
        end

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
    endfunction

    task report(string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // compare one accepted result with the oldest mean owed
    task check_mean(bf3_pkg::t_out_item got);
        bf3_pkg::t_out_item want;
        if (means_owed.size() == 0) begin
            report($sformatf("result %h with no mean owed", got));
            return;
        end
        want = means_owed.pop_front();
        if (got.red_out !== want.red_out)
            report($sformatf("red_out got %h want %h", got.red_out, want.red_out));
        if (got.green_out !== want.green_out)
            report($sformatf("green_out got %h want %h", got.green_out, want.green_out));
        if (got.blue_out !== want.blue_out)
            report($sformatf("blue_out got %h want %h", got.blue_out, want.blue_out));
        if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
    endtask
endclass

module tb_box_filter_3x3_edge_aware;
    import bf3_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 12;
    localparam int NOISE_PCT     = 5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    t_in_item              i_item;
    logic                  o_valid;
    logic                  i_stall;
    t_out_item             o_item;

    mean_scoreboard sb = new;
    int unsigned    tx_max = 8;
    int unsigned    rx_max = 8;
    int unsigned    cycle_count = 0;

    box_filter_3x3_edge_aware uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_in_item pixel(input logic [23:0] rgb);
        return {KIND_PIXEL, rgb};
    endfunction

    function automatic t_in_item rand_pixel();
        return {KIND_PIXEL, 24'($urandom)};
    endfunction

    // payload of a drain item is don't-care, so it carries noise
    function automatic t_in_item drain_tick();
        return {KIND_DRAIN, 24'($urandom)};
    endfunction

    // channel extremes for the 3x3 directed frame
    function automatic logic [23:0] probe_rgb(input int idx);
        case (idx)
            0:       return 24'hFFFFFF;
            1:       return 24'h000000;
            2:       return 24'hFF00AA;
            3:       return 24'h00FF55;
            4:       return 24'hAA55FF;
            5:       return 24'h55AA00;
            6:       return 24'hFFFFFF;
            7:       return 24'h010203;
            default: return 24'hFEFDFC;
        endcase
    endfunction

    // write both frame registers back to back, random order
    task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
        logic                  idx;
        logic [CFG_DATA_W-1:0] val;
        idx = 1'($urandom_range(0, 1));
        repeat (2) begin
            val = (idx == REG_FRAME_WIDTH) ? CFG_DATA_W'(w_raw) : CFG_DATA_W'(h_raw);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            sb.write_reg(idx, val);
            idx = ~idx;
        end
        i_cfg_we <= 1'b0;
    endtask

    // offer one item after a random gap and hold it until taken
    task automatic send(input t_in_item it);
        int unsigned gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_item(it);
    endtask

    // pixels of a frame, then optionally the flush, with dropped items mixed in
    task automatic feed(input int unsigned pixels, input bit flush, input int unsigned noise);
        int unsigned n;
        for (n = 0; n < pixels; n++) begin
            if ($urandom_range(0, 99) < noise) send(drain_tick());
            send(rand_pixel());
        end
        if (flush) begin
            for (n = 0; n <= sb.cols(); n++) begin
                if ($urandom_range(0, 99) < noise) send(rand_pixel());
                send(drain_tick());
            end
        end
    endtask

    // let every owed mean arrive and the pipeline go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stall before each item
    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = $urandom_range(0, rx_max);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            sb.check_mean(o_item);
        end
    end

    initial begin : stimulus
        int unsigned i, pick, w_raw, h_raw, area, start;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_item     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame: corner, edge and interior divisors
        set_frame(3, 3);
        for (i = 0; i < 9; i++) begin
            send(pixel(probe_rgb(i)));
            // drain inside the frame is dropped
            if (i == 4) send(drain_tick());
        end
        for (i = 0; i < 4; i++) begin
            send(drain_tick());
            // pixel during the flush is dropped
            if (i == 1) send(pixel(24'h123456));
        end
        settle();

        // single-pixel frame
        set_frame(1, 1);
        send(pixel(24'hFFFFFF));
        send(drain_tick());
        send(drain_tick());
        settle();

        // width above the line length clamps, results start past one full row
        set_frame(2047, 2);
        feed(1030, 1'b0, 0);
        settle();

        // zero height acts as one row
        set_frame(3, 0);
        feed(sb.cols() * sb.rows(), 1'b1, 0);
        settle();

        // widest and tallest frame, cut short by the next write
        set_frame(1024, 4096);
        feed(40, 1'b0, 0);
        settle();
        set_frame(1, 8191);
        feed(40, 1'b0, NOISE_PCT);
        settle();

        // random frames, mostly small and complete
        start = sb.items_used;
        while (sb.items_used - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) w_raw = 0;
            else if (pick < 10) w_raw = $urandom_range(1000, 2047);
            else if (pick < 75) w_raw = $urandom_range(1, 8);
            else w_raw = $urandom_range(9, 40);
            pick = $urandom_range(0, 99);
            if (pick < 5) h_raw = 0;
            else if (pick < 70) h_raw = $urandom_range(1, 6);
            else if (pick < 90) h_raw = $urandom_range(7, 12);
            else h_raw = $urandom_range(13, 8191);
            tx_max = ($urandom_range(0, 4) == 0) ? 0 : 8;
            rx_max = ($urandom_range(0, 4) == 0) ? 0 : 8;

            set_frame(w_raw, h_raw);
            area = sb.cols() * sb.rows();
            if (area > 400 || $urandom_range(0, 5) == 0) begin
                // aborted frame
                feed($urandom_range(1, (area < 400) ? area : 400), 1'b0, NOISE_PCT);
            end else begin
                // one or two complete frames back to back
                repeat ($urandom_range(1, 2)) feed(area, 1'b1, NOISE_PCT);
            end
            settle();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
